/* rtl/otab_pkg.sv */
package otab_pkg;

    localparam int PosW = 20;
    localparam int VelW = 12;
    localparam int DimW = 14;
    localparam int StW  = 3;
    localparam int EntW = 6;

    typedef enum logic [1:0] {
        ACT_SPAWN  = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_SPAWNED = 3'd0,
        ST_FULL    = 3'd1,
        ST_DELETED = 3'd2,
        ST_DEL_IGN = 3'd3,
        ST_UPDATED = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        CFG_GRAVITY = 1'b0,
        CFG_FALLLIM = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_WAIT,
        S_DEL_WR,
        S_TK_RDI,
        S_TK_WAITI,
        S_TK_LATI,
        S_TK_RDJ,
        S_TK_CMP,
        S_TK_WR
    } t_state;

    // one box record, all stores in one wide word
    typedef struct packed {
        logic [1:0]             flags;
        logic signed [DimW-1:0] dy;
        logic signed [DimW-1:0] dx;
        logic [DimW-1:0]        h;
        logic [DimW-1:0]        w;
        logic signed [VelW-1:0] vy;
        logic signed [VelW-1:0] vx;
        logic signed [PosW-1:0] py;
        logic signed [PosW-1:0] px;
    } t_box;

    localparam int BoxW = $bits(t_box);

    // rectangle in extended precision
    localparam int RW = 23;
    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] w;
        logic signed [RW-1:0] h;
    } t_rect;

    function automatic t_rect rect_of(input t_box b, input logic signed [RW-1:0] px,
                                      input logic signed [RW-1:0] py);
        t_rect r;
        r.x = px + RW'(b.dx);
        r.y = py + RW'(b.dy);
        r.w = RW'({1'b0, b.w});
        r.h = RW'({1'b0, b.h});
        return r;
    endfunction

    function automatic logic overlap(input t_rect a, input t_rect b);
        return (a.x < b.x + b.w) && (a.x + a.w > b.x) &&
               (a.y < b.y + b.h) && (a.y + a.h > b.y);
    endfunction

    function automatic logic signed [PosW-1:0] sat_pos(input logic signed [RW-1:0] v);
        if (v > RW'(524287))
            return PosW'(524287);
        else if (v < -RW'(524288))
            return PosW'(-524288);
        else
            return v[PosW-1:0];
    endfunction

endpackage

/* rtl/otab_ram.sv */
module otab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/object_table_aabb_motion_step.sv */
// Box table with per-axis motion step.
// Command channel: i_start with fields, taken when o_busy is low. Results
// appear one per cycle-strobe on o_valid with o_last on the final one; the
// receiver cannot stall, every result is taken on its strobe cycle.
// Spawn: one result, registered, in the cycle after start. Delete: one result
// after S_DEL_RD, S_DEL_WAIT, S_DEL_WR (moves the last record into the freed
// slot through the memory); a bad slot gives ST_DEL_IGN straight from idle.
// Tick: per box i, read i (S_TK_RDI, S_TK_WAITI, S_TK_LATI), prime the scan
// (S_TK_RDJ), scan all n boxes in S_TK_CMP one memory read per cycle (single
// read port) plus a closing step, then write back and emit (S_TK_WR). An empty
// tick gives one result in the cycle after start. Action 3 does nothing.
// Config channel: i_cfg_valid/o_cfg_ready with index and data; always ready,
// write only while idle. Reset (sync, active low) clears count and control,
// restores config defaults; the memory holds garbage until entries are spawned.
// Within a tick later boxes see earlier boxes already moved, since each
// record is written back before the next box is read.
module object_table_aabb_motion_step #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [1:0]             i_action,
    input  logic signed [15:0]     i_spawn_x,
    input  logic signed [15:0]     i_spawn_y,
    input  logic signed [11:0]     i_start_vel_x,
    input  logic signed [11:0]     i_start_vel_y,
    input  logic [13:0]            i_box_width,
    input  logic [13:0]            i_box_height,
    input  logic signed [13:0]     i_collider_dx,
    input  logic signed [13:0]     i_collider_dy,
    input  logic                   i_has_gravity,
    input  logic                   i_is_solid,
    input  logic [5:0]             i_slot,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [10:0]            i_cfg_data,
    output logic                   o_valid,
    output logic [2:0]             o_status,
    output logic [5:0]             o_entry,
    output logic signed [19:0]     o_now_x,
    output logic signed [19:0]     o_now_y,
    output logic signed [11:0]     o_now_vel_x,
    output logic signed [11:0]     o_now_vel_y,
    output logic                   o_hit_x,
    output logic                   o_hit_y,
    output logic                   o_last
);
    import otab_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_i, n_i, r_j, n_j, r_slot, n_slot;
    logic [CW-1:0] r_jc, n_jc;
    logic [7:0]  r_grav;
    logic [10:0] r_flim;
    t_box r_cur, n_cur;
    t_rect r_fx, n_fx, r_fy, n_fy;
    logic r_bx, n_bx, r_by, n_by;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_box          wdata, rdata;
    logic [BoxW-1:0] rdata_raw;

    otab_ram #(.WIDTH(BoxW), .DEPTH(TABLE_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );
    assign rdata = t_box'(rdata_raw);

    logic          n_valid, r_valid;
    logic [2:0]    n_status, r_status;
    logic [5:0]    n_entry, r_entry;
    logic signed [19:0] n_ox, n_oy, r_ox, r_oy;
    logic signed [11:0] n_ovx, n_ovy, r_ovx, r_ovy;
    logic n_hx, n_hy, n_last, r_hx, r_hy, r_last;

    logic take;
    logic del_ok;
    assign take = i_start && (r_state == S_IDLE);
    assign del_ok = 7'(i_slot) < 7'(r_count);
    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && t_action'(i_action) == ACT_DELETE && del_ok)
                    n_state = S_DEL_RD;
                else if (take && t_action'(i_action) == ACT_TICK && r_count != '0)
                    n_state = S_TK_RDI;
            end
            S_DEL_RD:   n_state = S_DEL_WAIT;
            S_DEL_WAIT: n_state = S_DEL_WR;
            S_DEL_WR:   n_state = S_IDLE;
            S_TK_RDI:   n_state = S_TK_WAITI;
            S_TK_WAITI: n_state = S_TK_LATI;
            S_TK_LATI:  n_state = S_TK_RDJ;
            S_TK_RDJ:   n_state = S_TK_CMP;
            S_TK_CMP:   n_state = (r_jc == r_count) ? S_TK_WR : S_TK_CMP;
            S_TK_WR:    n_state = (CW'(r_i) + 1'b1 == r_count) ? S_IDLE : S_TK_RDI;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    logic signed [12:0] vy_g, lim;
    logic signed [RW-1:0] npx, npy;
    t_rect hb;
    always_comb begin
        n_count = r_count; n_i = r_i; n_j = r_j; n_jc = r_jc; n_slot = r_slot;
        n_cur = r_cur; n_fx = r_fx; n_fy = r_fy; n_bx = r_bx; n_by = r_by;
        we = 1'b0; waddr = r_i; wdata = r_cur; raddr = r_i;
        n_valid = 1'b0; n_status = ST_SPAWNED; n_entry = '0;
        n_ox = '0; n_oy = '0; n_ovx = '0; n_ovy = '0;
        n_hx = 1'b0; n_hy = 1'b0; n_last = 1'b1;
        lim = (r_flim > 11'd1024) ? 13'sd1024 : 13'($signed({2'b0, r_flim}));
        vy_g = '0; npx = '0; npy = '0;
        hb = rect_of(rdata, RW'(rdata.px), RW'(rdata.py));
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (t_action'(i_action))
                        ACT_SPAWN: begin
                            n_valid = 1'b1;
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                wdata.px = {i_spawn_x, 4'b0};
                                wdata.py = {i_spawn_y, 4'b0};
                                wdata.vx = (i_start_vel_x < -12'sd1024) ? -12'sd1024 :
                                           (i_start_vel_x > 12'sd1024) ? 12'sd1024 :
                                           i_start_vel_x;
                                wdata.vy = (i_start_vel_y < -12'sd1024) ? -12'sd1024 :
                                           (i_start_vel_y > 12'sd1024) ? 12'sd1024 :
                                           i_start_vel_y;
                                wdata.w = i_box_width; wdata.h = i_box_height;
                                wdata.dx = i_collider_dx; wdata.dy = i_collider_dy;
                                wdata.flags = {i_is_solid, i_has_gravity};
                                we = 1'b1; waddr = r_count[AW-1:0];
                                n_count = r_count + 1'b1;
                                n_status = ST_SPAWNED; n_entry = 6'(r_count);
                                n_ox = wdata.px; n_oy = wdata.py;
                                n_ovx = wdata.vx; n_ovy = wdata.vy;
                            end
                        end
                        ACT_DELETE: begin
                            n_valid = 1'b1; n_entry = i_slot;
                            if (del_ok) begin
                                n_valid = 1'b0;
                                n_slot = i_slot[AW-1:0];
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = ST_DEL_IGN;
                            end
                        end
                        ACT_TICK: begin
                            n_i = '0;
                            if (r_count == '0) begin
                                n_valid = 1'b1; n_status = ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DEL_RD: raddr = r_count[AW-1:0];
            S_DEL_WAIT: raddr = r_count[AW-1:0];
            S_DEL_WR: begin
                we = 1'b1; waddr = r_slot; wdata = rdata;
                n_valid = 1'b1; n_status = ST_DELETED; n_entry = 6'(r_slot);
            end
            S_TK_RDI: raddr = r_i;
            S_TK_WAITI: raddr = r_i;
            S_TK_LATI: begin
                n_cur = rdata;
                vy_g = 13'(rdata.vy);
                if (rdata.flags[0]) begin
                    vy_g = vy_g + 13'($signed({5'b0, r_grav}));
                    if (vy_g > lim) vy_g = lim;
                end
                n_cur.vy = vy_g[11:0];
                n_fx = rect_of(rdata, RW'(rdata.px) + RW'(rdata.vx), RW'(rdata.py));
                n_fy = rect_of(rdata, RW'(rdata.px), RW'(rdata.py) + RW'(vy_g));
                n_bx = 1'b0; n_by = 1'b0;
                n_j = '0; n_jc = '0;
                raddr = '0;
            end
            S_TK_RDJ: begin
                raddr = r_j;
            end
            S_TK_CMP: begin
                raddr = r_j + 1'b1;
                n_j = r_j + 1'b1;
                n_jc = r_jc + 1'b1;
                if (r_cur.flags[1] && rdata.flags[1] && r_jc != CW'(r_i) &&
                    r_jc < r_count) begin
                    if (overlap(r_fx, hb)) n_bx = 1'b1;
                    if (overlap(r_fy, hb)) n_by = 1'b1;
                end
            end
            S_TK_WR: begin
                npx = RW'(r_cur.px) + RW'(r_cur.vx);
                npy = RW'(r_cur.py) + RW'(r_cur.vy);
                if (r_bx) wdata.vx = '0; else wdata.px = sat_pos(npx);
                if (r_by) wdata.vy = '0; else wdata.py = sat_pos(npy);
                we = 1'b1; waddr = r_i;
                n_valid = 1'b1; n_status = ST_UPDATED; n_entry = 6'(r_i);
                n_ox = wdata.px; n_oy = wdata.py; n_ovx = wdata.vx; n_ovy = wdata.vy;
                n_hx = r_bx; n_hy = r_by;
                n_last = (CW'(r_i) + 1'b1 == r_count);
                n_i = r_i + 1'b1;
                raddr = r_i + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_grav  <= 8'd4;
            r_flim  <= 11'd128;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_valid) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_GRAVITY) r_grav <= i_cfg_data[7:0];
                else r_flim <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_jc <= n_jc; r_slot <= n_slot;
        r_cur <= n_cur; r_fx <= n_fx; r_fy <= n_fy; r_bx <= n_bx; r_by <= n_by;
        r_status <= n_status; r_entry <= n_entry;
        r_ox <= n_ox; r_oy <= n_oy; r_ovx <= n_ovx; r_ovy <= n_ovy;
        r_hx <= n_hx; r_hy <= n_hy; r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_entry = r_entry;
    assign o_now_x = r_ox;
    assign o_now_y = r_oy;
    assign o_now_vel_x = r_ovx;
    assign o_now_vel_y = r_ovy;
    assign o_hit_x = r_hx;
    assign o_hit_y = r_hy;
    assign o_last = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("count over depth");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> !o_valid) else $error("spurious result");
    a_hit_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hit_x || o_hit_y)) |-> o_status == ST_UPDATED)
        else $error("hit outside tick");
endmodule
